/* src/mrc_pkg.sv */
// mrc_pkg: shared constants, codes and types of the mixed-radix counter
// no dependencies; used by mrc_div and mixed_radix_counter
package mrc_pkg;

	localparam int NUM_DIGITS_DEF  = 8;
	localparam int DIGIT_WIDTH_DEF = 8;
	localparam int REG_COUNT       = 8;
	localparam int LIMIT_W         = 8;
	localparam int CFG_IDX_W       = 4;
	localparam int VALUE_W         = 64;
	localparam int OP_W            = 2;
	localparam int IN_W            = 72;
	localparam int OUT_W           = 200;
	localparam int DIV_BITS        = 8;
	localparam int DIV_STEPS       = VALUE_W / DIV_BITS;
	localparam int DIV_CNT_W       = $clog2(DIV_STEPS);

	typedef enum logic [OP_W-1:0] {
		OP_INC  = 2'd0,
		OP_LOAD = 2'd1,
		OP_READ = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_MUL_D,
		ST_MUL_L,
		ST_ACC,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic load;
		logic step;
		logic last;
	} div_ctl_t;

endpackage

/* src/mixed_radix_counter.sv */
// mixed_radix_counter: NUM_DIGITS-digit (eight by default) mixed-radix counter with load, increment and read
// each digit passes through ST_MUL_D, ST_MUL_L and ST_ACC on its way to the result;
// a load first runs every digit through the shared divider in ST_DIV
// no new item is taken until the current result is in the output register; the multiplier is shared by all digits
// reset: digits, limits and all control state reset asynchronously by arst_n
// depends on mrc_pkg and mrc_div
module mixed_radix_counter #(
	parameter int NUM_DIGITS  = mrc_pkg::NUM_DIGITS_DEF,
	parameter int DIGIT_WIDTH = mrc_pkg::DIGIT_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [mrc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mrc_pkg::LIMIT_W-1:0]   cfg_data,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// op, load_value
	input  logic [mrc_pkg::IN_W-1:0]      s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// digits_packed, integer_value, max_value, ok
	output logic [mrc_pkg::OUT_W-1:0]     m_tdata
);
	import mrc_pkg::*;

	localparam int IDX_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_DIGITS - 1);
	localparam logic [LIMIT_W-1:0] DIGIT_MAX = LIMIT_W'((1 << DIGIT_WIDTH) - 1);
	localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

	state_t state_q, state_d;
	div_ctl_t div_ctl;

	logic [LIMIT_W-1:0]     limit_q [REG_COUNT];
	logic [DIGIT_WIDTH-1:0] lim_eff [NUM_DIGITS];
	logic [DIGIT_WIDTH-1:0] digit_q [NUM_DIGITS];
	logic [DIGIT_WIDTH-1:0] inc_digit [NUM_DIGITS];
	logic                   inc_found;

	logic [IDX_W-1:0]     idx_q;
	logic [DIV_CNT_W-1:0] step_q;
	op_t                  op_q;
	logic                 ok_q;
	logic [VALUE_W-1:0]   w_q, val_q, max_q, mul_q;
	logic [VALUE_W-1:0]   packed_digits;
	logic [DIGIT_WIDTH-1:0] mul_b;
	logic [VALUE_W+DIGIT_WIDTH-1:0] mul_full;
	logic [DIGIT_WIDTH:0]   radix;
	logic [DIGIT_WIDTH-1:0] rem_d;
	logic [VALUE_W-1:0]     quot_d;
	logic                   in_acc;
	op_t                    in_op;

	assign in_acc = s_tvalid && s_tready;
	assign in_op  = op_t'(s_tdata[OP_W-1:0]);

	always_comb begin
		for (int k = 0; k < NUM_DIGITS; k++) begin
			lim_eff[k] = (limit_q[k] > DIGIT_MAX) ? DIGIT_MAX[DIGIT_WIDTH-1:0]
				: limit_q[k][DIGIT_WIDTH-1:0];
		end
	end

	// odometer step: first digit below its limit goes up, lower ones clear
	always_comb begin
		inc_found = 1'b0;
		for (int k = 0; k < NUM_DIGITS; k++) begin
			if (inc_found) begin
				inc_digit[k] = digit_q[k];
			end else if (digit_q[k] < lim_eff[k]) begin
				inc_digit[k] = digit_q[k] + 1'b1;
				inc_found = 1'b1;
			end else begin
				inc_digit[k] = '0;
			end
		end
	end

	always_comb begin
		packed_digits = '0;
		for (int k = 0; k < NUM_DIGITS; k++) begin
			packed_digits[k*DIGIT_WIDTH +: DIGIT_WIDTH] = digit_q[k];
		end
	end

	assign radix    = {1'b0, lim_eff[idx_q]} + 1'b1;
	assign mul_b    = (state_q == ST_MUL_D) ? digit_q[idx_q] : lim_eff[idx_q];
	assign mul_full = w_q * mul_b;

	mrc_div #(
		.DIGIT_WIDTH(DIGIT_WIDTH)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (div_ctl),
		.value  (s_tdata[OP_W +: VALUE_W]),
		.radix  (radix),
		.rem_d  (rem_d),
		.quot_d (quot_d)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					state_d = (in_op == OP_LOAD) ? ST_DIV : ST_MUL_D;
				end
			end
			ST_DIV: begin
				if (step_q == DIV_LAST && idx_q == LAST_IDX) begin
					state_d = ST_MUL_D;
				end
			end
			ST_MUL_D: state_d = ST_MUL_L;
			ST_MUL_L: state_d = ST_ACC;
			ST_ACC: begin
				state_d = (idx_q == LAST_IDX) ? ST_OUT : ST_MUL_D;
			end
			ST_OUT: begin
				if (!m_tvalid || m_tready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		s_tready = 1'b0;
		div_ctl = '0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				div_ctl.load = s_tvalid && (in_op == OP_LOAD);
			end
			ST_DIV: begin
				div_ctl.step = 1'b1;
				div_ctl.last = (step_q == DIV_LAST);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			m_tvalid <= 1'b0;
			idx_q <= '0;
			step_q <= '0;
			op_q <= OP_READ;
			ok_q <= 1'b1;
			for (int k = 0; k < REG_COUNT; k++) begin
				limit_q[k] <= '0;
			end
			for (int k = 0; k < NUM_DIGITS; k++) begin
				digit_q[k] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (cfg_we && cfg_index < CFG_IDX_W'(REG_COUNT)) begin
				limit_q[cfg_index[$clog2(REG_COUNT)-1:0]] <= cfg_data;
			end
			if (state_q == ST_OUT && (!m_tvalid || m_tready)) begin
				m_tvalid <= 1'b1;
			end else if (m_tvalid && m_tready) begin
				m_tvalid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					idx_q <= '0;
					step_q <= '0;
					if (in_acc) begin
						op_q <= in_op;
						ok_q <= (in_op == OP_INC) ? inc_found : 1'b1;
						if (in_op == OP_INC && inc_found) begin
							digit_q <= inc_digit;
						end
					end
				end
				ST_DIV: begin
					step_q <= step_q + 1'b1;
					if (step_q == DIV_LAST) begin
						digit_q[idx_q] <= rem_d;
						if (idx_q == LAST_IDX) begin
							idx_q <= '0;
							ok_q <= (quot_d == '0);
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				ST_ACC: begin
					if (idx_q != LAST_IDX) begin
						idx_q <= idx_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// shared multiplier and accumulators
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				w_q <= VALUE_W'(1);
				val_q <= '0;
				max_q <= '0;
			end
			ST_MUL_D: begin
				mul_q <= mul_full[VALUE_W-1:0];
			end
			ST_MUL_L: begin
				val_q <= val_q + mul_q;
				mul_q <= mul_full[VALUE_W-1:0];
			end
			ST_ACC: begin
				max_q <= max_q + mul_q;
				w_q <= w_q + mul_q;
			end
			ST_OUT: begin
				if (!m_tvalid || m_tready) begin
					m_tdata <= {{(OUT_W-3*VALUE_W-1){1'b0}}, ok_q, max_q, val_q,
						packed_digits};
				end
			end
			default: ;
		endcase
	end

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !s_tready)
		else $error("item accepted while busy");

	a_div_only_on_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (op_q == OP_LOAD))
		else $error("divider running for a non-load item");

	a_result_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> ($past(state_q) == ST_OUT))
		else $error("result raised outside the output step");

	a_ok_only_inc_load: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_OUT) && !ok_q) |-> (op_q == OP_INC || op_q == OP_LOAD))
		else $error("failure flag on a read item");

endmodule

/* src/mrc_div.sv */
// mrc_div: iterative divider of a 64-bit value by a small radix, 8 quotient bits per step
// depends on mrc_pkg
module mrc_div #(
	parameter int DIGIT_WIDTH = mrc_pkg::DIGIT_WIDTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  mrc_pkg::div_ctl_t          ctl,
	input  logic [mrc_pkg::VALUE_W-1:0] value,
	input  logic [DIGIT_WIDTH:0]       radix,
	output logic [DIGIT_WIDTH-1:0]     rem_d,
	output logic [mrc_pkg::VALUE_W-1:0] quot_d
);
	import mrc_pkg::*;

	logic [VALUE_W-1:0]     quot_q;
	logic [DIGIT_WIDTH-1:0] rem_q;
	logic                   active_q;
	logic [DIV_BITS-1:0]    qbyte;
	logic [DIGIT_WIDTH:0]   trial;
	logic [DIGIT_WIDTH-1:0] r;

	// restoring division over the top byte of the running quotient
	always_comb begin
		r = rem_q;
		qbyte = '0;
		trial = '0;
		for (int b = 0; b < DIV_BITS; b++) begin
			trial = {r, quot_q[VALUE_W-1-b]};
			if (trial >= radix) begin
				trial = trial - radix;
				qbyte[DIV_BITS-1-b] = 1'b1;
			end
			r = trial[DIGIT_WIDTH-1:0];
		end
		rem_d = r;
		quot_d = {quot_q[VALUE_W-DIV_BITS-1:0], qbyte};
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			quot_q <= value;
			rem_q <= '0;
		end else if (ctl.step) begin
			quot_q <= quot_d;
			rem_q <= ctl.last ? '0 : rem_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
		end else if (ctl.load) begin
			active_q <= 1'b1;
		end else if (ctl.step && ctl.last && quot_d == '0) begin
			active_q <= active_q;
		end
	end

	a_step_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.step |-> active_q)
		else $error("divider stepped before any load");

	a_no_load_and_step: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctl.load && ctl.step))
		else $error("divider load and step together");

	a_rem_below_radix: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.step |-> ({1'b0, rem_d} < radix))
		else $error("remainder not below radix");

endmodule
